[rtl/core/http_response_header_scanner_macros.svh]
// Assertion macros for the HTTP response header scanner.
// Needs clk and rst_n in the scope of every use.
`ifndef HTTP_RESPONSE_HEADER_SCANNER_MACROS_SVH
`define HTTP_RESPONSE_HEADER_SCANNER_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define HRS_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("%m: same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define HRS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("%m: next-cycle check failed");

`endif

[rtl/core/hrs_pkg.sv]
// Shared types, byte codes and prefix tables of the header scanner.
// No dependencies; used by every module of the block but hrs_fifo.
`default_nettype none

package hrs_pkg;

  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 31;

  localparam logic [CFG_IDX_W-1:0] REG_DEFAULT_MAX_AGE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_SCAN_LIMIT      = 1'b1;

  localparam logic [30:0] DEFAULT_MAX_AGE_RST = 31'd60;
  localparam logic [15:0] SCAN_LIMIT_RST      = 16'd16000;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_VT    = 8'h0B;
  localparam logic [7:0] CH_FF    = 8'h0C;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_EQ    = 8'h3D;

  // last three bytes before the final LF of CR LF CR LF
  localparam logic [23:0] TERM_HEAD = 24'h0D0A0D;

  localparam logic [3:0] CLEN_LEN = 4'd14;
  localparam logic [3:0] CC_LEN   = 4'd13;
  localparam logic [3:0] MA_LEN   = 4'd7;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last;
  } hrs_in_t;

  typedef struct packed {
    logic               found;
    logic [15:0]        hdr_len;
    logic signed [31:0] clen;
    logic signed [31:0] max_age;
  } hrs_out_t;

  // classified byte passed from front to back
  typedef struct packed {
    logic [7:0]  data_byte;
    logic        act;        // byte goes through the tokeniser
    logic        term;       // byte completes CR LF CR LF
    logic        last;
    logic [15:0] found_len;
  } hrs_item_t;

  typedef struct packed {
    logic [30:0] dflt_age;
    logic        reload;     // reload max-age before the first byte
  } hrs_cfg_t;

  function automatic logic [7:0] clen_char(input logic [3:0] idx);
    logic [7:0] c;
    unique case (idx)
      4'd0:    c = "C";
      4'd1:    c = "o";
      4'd2:    c = "n";
      4'd3:    c = "t";
      4'd4:    c = "e";
      4'd5:    c = "n";
      4'd6:    c = "t";
      4'd7:    c = "-";
      4'd8:    c = "L";
      4'd9:    c = "e";
      4'd10:   c = "n";
      4'd11:   c = "g";
      4'd12:   c = "t";
      4'd13:   c = "h";
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  function automatic logic [7:0] cc_char(input logic [3:0] idx);
    logic [7:0] c;
    unique case (idx)
      4'd0:    c = "C";
      4'd1:    c = "a";
      4'd2:    c = "c";
      4'd3:    c = "h";
      4'd4:    c = "e";
      4'd5:    c = "-";
      4'd6:    c = "C";
      4'd7:    c = "o";
      4'd8:    c = "n";
      4'd9:    c = "t";
      4'd10:   c = "r";
      4'd11:   c = "o";
      4'd12:   c = "l";
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  function automatic logic [7:0] ma_char(input logic [3:0] idx);
    logic [7:0] c;
    unique case (idx)
      4'd0:    c = "m";
      4'd1:    c = "a";
      4'd2:    c = "x";
      4'd3:    c = "-";
      4'd4:    c = "a";
      4'd5:    c = "g";
      4'd6:    c = "e";
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

[rtl/core/http_response_header_scanner.sv]
// A result is pushed to the result queue when the back end executes its last byte.
// Throughput: one byte per cycle while not in_full; the back end pops one per cycle.
// in_full rises only when the work queue is full, i.e. the result queue is backed up.
// Reset (synchronous, rst_n low) empties both queues, clears the scan state and
// restores the default max-age to 60 and scan_limit to 16000.
// Depends on hrs_pkg, hrs_fifo, hrs_front and hrs_back.
`default_nettype none

module http_response_header_scanner #(
  parameter int unsigned WORK_DEPTH = 2,
  parameter int unsigned RES_DEPTH  = 2
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_push,
  input  wire hrs_pkg::hrs_in_t               in_data,
  output logic                                in_full,
  output logic                                out_empty,
  input  wire logic                           out_pop,
  output hrs_pkg::hrs_out_t                   out_data,
  input  wire logic                           cfg_we,
  input  wire logic [hrs_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [hrs_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import hrs_pkg::*;

  localparam int unsigned ITEM_W = $bits(hrs_item_t);
  localparam int unsigned RES_W  = $bits(hrs_out_t);

  logic [30:0] dflt_max_age_r;
  logic [15:0] scan_limit_r;

  logic        q_push, q_full, q_empty, q_pop;
  hrs_item_t   q_wr_item, q_rd_item;
  logic [ITEM_W-1:0] q_rdata;
  logic        pos_zero;
  hrs_cfg_t    back_cfg;
  logic        res_push, res_full;
  hrs_out_t    res_data;
  logic [RES_W-1:0] res_rdata;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dflt_max_age_r <= DEFAULT_MAX_AGE_RST;
      scan_limit_r   <= SCAN_LIMIT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_DEFAULT_MAX_AGE: dflt_max_age_r <= cfg_wdata[30:0];
        REG_SCAN_LIMIT:      scan_limit_r   <= cfg_wdata[15:0];
        default: ;
      endcase
    end
  end

  assign back_cfg.dflt_age = (cfg_we && (cfg_index == REG_DEFAULT_MAX_AGE)) ?
                             cfg_wdata[30:0] : dflt_max_age_r;
  assign back_cfg.reload = cfg_we && (cfg_index == REG_DEFAULT_MAX_AGE) && pos_zero;

  assign in_full = q_full;

  hrs_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_push    (in_push),
    .in_data    (in_data),
    .q_full     (q_full),
    .scan_limit (scan_limit_r),
    .q_push     (q_push),
    .q_item     (q_wr_item),
    .pos_zero   (pos_zero)
  );

  hrs_fifo #(
    .WIDTH (ITEM_W),
    .DEPTH (WORK_DEPTH)
  ) u_work_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wr_item),
    .full  (q_full),
    .pop   (q_pop),
    .rdata (q_rdata),
    .empty (q_empty)
  );

  assign q_rd_item = hrs_item_t'(q_rdata);

  hrs_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (!q_empty),
    .item       (q_rd_item),
    .item_pop   (q_pop),
    .cfg        (back_cfg),
    .res_full   (res_full),
    .res_push   (res_push),
    .res_data   (res_data)
  );

  hrs_fifo #(
    .WIDTH (RES_W),
    .DEPTH (RES_DEPTH)
  ) u_res_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (res_push),
    .wdata (res_data),
    .full  (res_full),
    .pop   (out_pop),
    .rdata (res_rdata),
    .empty (out_empty)
  );

  assign out_data = hrs_out_t'(res_rdata);

endmodule

`default_nettype wire

[rtl/core/hrs_fifo.sv]
// Small flip-flop queue, first in first out, combinational read of the head.
// No dependencies.
`default_nettype none

module hrs_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] wdata,
  output logic                  full,
  input  wire logic             pop,
  output logic [WIDTH-1:0]      rdata,
  output logic                  empty
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] cnt_r;
  logic             do_push, do_pop;

  assign full    = (cnt_r == FULL_CNT);
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + 1'b1;
      end
      unique case ({do_push, do_pop})
        2'b10:   cnt_r <= cnt_r + 1'b1;
        2'b01:   cnt_r <= cnt_r - 1'b1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

endmodule

`default_nettype wire

[rtl/core/hrs_front.sv]
// Front end: byte position, scan limit, NUL stop and CR LF CR LF detection.
// Depends on hrs_pkg; feeds classified bytes into the work queue.
`default_nettype none

module hrs_front (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_push,
  input  wire hrs_pkg::hrs_in_t  in_data,
  input  wire logic              q_full,
  input  wire logic [15:0]       scan_limit,
  output logic                   q_push,
  output hrs_pkg::hrs_item_t     q_item,
  output logic                   pos_zero
);
  import hrs_pkg::*;

  logic [15:0] pos_r, pos_nxt;
  logic [23:0] recent_r, recent_nxt;
  logic        done_r, done_nxt;
  logic        accept, live, term;

  assign accept   = in_push && !q_full;
  assign pos_zero = (pos_r == '0);
  assign live     = !done_r && (pos_r < scan_limit);
  assign term     = live && (in_data.data_byte == CH_LF) && (recent_r == TERM_HEAD);

  always_comb begin
    pos_nxt    = pos_r;
    recent_nxt = recent_r;
    done_nxt   = done_r;
    if (accept) begin
      if (live) begin
        if (in_data.data_byte == CH_NUL) begin
          done_nxt = 1'b1;
        end else begin
          recent_nxt = {recent_r[15:0], in_data.data_byte};
          if (term) begin
            done_nxt = 1'b1;
          end
        end
      end
      if (pos_r != 16'hFFFF) begin
        pos_nxt = pos_r + 16'd1;
      end
      if (in_data.last) begin
        pos_nxt    = '0;
        recent_nxt = '0;
        done_nxt   = 1'b0;
      end
    end
  end

  assign q_push           = accept;
  assign q_item.data_byte = in_data.data_byte;
  assign q_item.act       = live && (in_data.data_byte != CH_NUL);
  assign q_item.term      = term;
  assign q_item.last      = in_data.last;
  assign q_item.found_len = pos_r + 16'd1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r    <= '0;
      recent_r <= '0;
      done_r   <= 1'b0;
    end else begin
      pos_r    <= pos_nxt;
      recent_r <= recent_nxt;
      done_r   <= done_nxt;
    end
  end

endmodule

`default_nettype wire

[rtl/core/hrs_back.sv]
// Back end: tokeniser, prefix match, decimal accumulate and result build.
// Depends on hrs_pkg and the assertion macro header.
`default_nettype none
`include "http_response_header_scanner_macros.svh"

module hrs_back (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               item_valid,
  input  wire hrs_pkg::hrs_item_t item,
  output logic                    item_pop,
  input  wire hrs_pkg::hrs_cfg_t  cfg,
  input  wire logic               res_full,
  output logic                    res_push,
  output hrs_pkg::hrs_out_t       res_data
);
  import hrs_pkg::*;

  typedef enum logic [1:0] {
    MODE_NAME,
    MODE_CLEN,
    MODE_DIRECTIVE,
    MODE_MAXAGE
  } mode_t;

  typedef enum logic [1:0] {
    PH_LEAD,
    PH_DIGITS,
    PH_DONE
  } phase_t;

  mode_t       mode_r, mode_nxt;
  logic [1:0]  tok_cnt_r, tok_cnt_nxt;
  logic [3:0]  ci_r, ci_nxt;
  logic [2:0]  flags_r, flags_nxt;
  logic        in_tok_r, in_tok_nxt;
  logic [31:0] acc_r, acc_nxt;
  phase_t      ph_r, ph_nxt;
  logic        neg_r, neg_nxt;
  logic [31:0] clv_r, clv_nxt;
  logic [31:0] mav_r, mav_nxt;
  logic        found_r, found_nxt;
  logic [15:0] len_r, len_nxt;

  logic [7:0]  b;
  logic        digit, delim, num_mode, skip;
  logic [3:0]  dval;
  logic [35:0] prod, lim;
  logic [31:0] num_val;

  assign item_pop = item_valid && !(item.last && res_full);
  assign res_push = item_pop && item.last;

  assign b        = item.data_byte;
  assign digit    = (b >= CH_ZERO) && (b <= CH_NINE);
  assign dval     = 4'(b - CH_ZERO);
  assign num_val  = neg_r ? (32'd0 - acc_r) : acc_r;
  assign delim    = (b == CH_CR) || (b == CH_LF) || (b == CH_COLON) || (b == CH_SPACE) ||
                    (((mode_r == MODE_DIRECTIVE) || (mode_r == MODE_MAXAGE)) && (b == CH_EQ));
  assign num_mode = (mode_r == MODE_CLEN) || (mode_r == MODE_MAXAGE);

  always_comb begin
    mode_nxt    = mode_r;
    tok_cnt_nxt = tok_cnt_r;
    ci_nxt      = ci_r;
    flags_nxt   = flags_r;
    in_tok_nxt  = in_tok_r;
    acc_nxt     = acc_r;
    ph_nxt      = ph_r;
    neg_nxt     = neg_r;
    clv_nxt     = clv_r;
    mav_nxt     = mav_r;
    found_nxt   = found_r;
    len_nxt     = len_r;
    skip        = 1'b0;
    prod        = '0;
    lim         = '0;

    if (item_pop && item.act) begin
      if (delim) begin
        if (in_tok_r) begin
          unique case (mode_r)
            MODE_NAME: begin
              if (tok_cnt_r != 2'd3) begin
                tok_cnt_nxt = tok_cnt_r + 2'd1;
              end else if (flags_r[0] && (ci_r >= CLEN_LEN)) begin
                mode_nxt = MODE_CLEN;
              end else if (flags_r[1] && (ci_r >= CC_LEN)) begin
                mode_nxt = MODE_DIRECTIVE;
              end
            end
            MODE_CLEN: begin
              clv_nxt  = num_val;
              mode_nxt = MODE_NAME;
            end
            MODE_DIRECTIVE: begin
              mode_nxt = (flags_r[2] && (ci_r >= MA_LEN)) ? MODE_MAXAGE : MODE_NAME;
            end
            MODE_MAXAGE: begin
              mav_nxt  = num_val;
              mode_nxt = MODE_NAME;
            end
            default: mode_nxt = MODE_NAME;
          endcase
          in_tok_nxt = 1'b0;
        end
      end else begin
        if (!in_tok_r) begin
          in_tok_nxt = 1'b1;
          ci_nxt     = '0;
          flags_nxt  = 3'b111;
          acc_nxt    = '0;
          ph_nxt     = PH_LEAD;
          neg_nxt    = 1'b0;
        end
        if ((ci_nxt < CLEN_LEN) && (b != clen_char(ci_nxt))) flags_nxt[0] = 1'b0;
        if ((ci_nxt < CC_LEN) && (b != cc_char(ci_nxt)))     flags_nxt[1] = 1'b0;
        if ((ci_nxt < MA_LEN) && (b != ma_char(ci_nxt)))     flags_nxt[2] = 1'b0;
        if (num_mode) begin
          // atoi: leading tab/VT/FF, optional sign, then digits
          if (ph_nxt == PH_LEAD) begin
            if ((b == CH_TAB) || (b == CH_VT) || (b == CH_FF)) begin
              skip = 1'b1;
            end else if ((b == CH_PLUS) || (b == CH_MINUS)) begin
              ph_nxt  = PH_DIGITS;
              neg_nxt = (b == CH_MINUS);
              skip    = 1'b1;
            end else if (!digit) begin
              ph_nxt  = PH_DONE;
              neg_nxt = 1'b0;
              skip    = 1'b1;
            end else begin
              ph_nxt = PH_DIGITS;
            end
          end
          if (!skip && (ph_nxt == PH_DIGITS)) begin
            if (!digit) begin
              ph_nxt = PH_DONE;
            end else begin
              prod = ({4'd0, acc_nxt} << 3) + ({4'd0, acc_nxt} << 1) + {32'd0, dval};
              lim  = neg_nxt ? 36'h080000000 : 36'h07FFFFFFF;
              acc_nxt = (prod > lim) ? lim[31:0] : prod[31:0];
            end
          end
        end
        if (ci_nxt != 4'd15) begin
          ci_nxt = ci_nxt + 4'd1;
        end
      end
      if (item.term) begin
        found_nxt = 1'b1;
        len_nxt   = item.found_len;
      end
    end

    res_data.found   = found_nxt;
    res_data.hdr_len = found_nxt ? len_nxt : 16'd0;
    res_data.clen    = found_nxt ? clv_nxt : 32'hFFFF_FFFF;
    res_data.max_age = found_nxt ? mav_nxt : {1'b0, cfg.dflt_age};

    if (res_push) begin
      // fresh message state
      mode_nxt    = MODE_NAME;
      tok_cnt_nxt = '0;
      ci_nxt      = '0;
      flags_nxt   = 3'b111;
      in_tok_nxt  = 1'b0;
      acc_nxt     = '0;
      ph_nxt      = PH_LEAD;
      neg_nxt     = 1'b0;
      clv_nxt     = 32'hFFFF_FFFF;
      mav_nxt     = {1'b0, cfg.dflt_age};
      found_nxt   = 1'b0;
      len_nxt     = '0;
    end else if (cfg.reload) begin
      mav_nxt = {1'b0, cfg.dflt_age};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r    <= MODE_NAME;
      tok_cnt_r <= '0;
      ci_r      <= '0;
      flags_r   <= 3'b111;
      in_tok_r  <= 1'b0;
      acc_r     <= '0;
      ph_r      <= PH_LEAD;
      neg_r     <= 1'b0;
      clv_r     <= 32'hFFFF_FFFF;
      mav_r     <= {1'b0, DEFAULT_MAX_AGE_RST};
      found_r   <= 1'b0;
      len_r     <= '0;
    end else begin
      mode_r    <= mode_nxt;
      tok_cnt_r <= tok_cnt_nxt;
      ci_r      <= ci_nxt;
      flags_r   <= flags_nxt;
      in_tok_r  <= in_tok_nxt;
      acc_r     <= acc_nxt;
      ph_r      <= ph_nxt;
      neg_r     <= neg_nxt;
      clv_r     <= clv_nxt;
      mav_r     <= mav_nxt;
      found_r   <= found_nxt;
      len_r     <= len_nxt;
    end
  end

  // value modes only follow the skipped status line
  `HRS_ASSERT_SAME(a_mode_after_status, mode_r != MODE_NAME, tok_cnt_r == 2'd3)
  // a delivered result leaves the tokeniser at message start
  `HRS_ASSERT_NEXT(a_clear_after_result, res_push, !found_r && !in_tok_r && mode_r == MODE_NAME)
  // number phase never reaches the unused code
  `HRS_ASSERT_SAME(a_phase_legal, 1'b1, (ph_r == PH_LEAD) || (ph_r == PH_DIGITS) || (ph_r == PH_DONE))

endmodule

`default_nettype wire

[bench/testbench.sv]
`timescale 1ns / 100ps
// Self-checking bench for http_response_header_scanner: framed response buffers in,
// one parsed header summary out per buffer. Needs hrs_pkg and the scanner RTL.

import hrs_pkg::*;

// Tracks the scanner state byte by byte and holds the header summaries still owed.
class header_ledger;
  typedef enum logic [1:0] {FIELD_NAME, CLEN_VALUE, DIRECTIVE, AGE_VALUE} scan_mode_e;
  typedef enum logic [1:0] {NUM_LEAD, NUM_DIGITS, NUM_DONE} num_phase_e;

  string clen_word = "Content-Length";
  string cc_word   = "Cache-Control";
  string age_word  = "max-age";

  logic [30:0] dflt_age;
  logic [15:0] limit_q;

  logic [15:0] pos;
  logic [23:0] tail3;
  bit          halted;
  bit          term_seen;
  logic [15:0] term_len;
  logic [1:0]  tok_count;
  scan_mode_e  mode;
  logic [3:0]  ch_idx;
  logic [2:0]  pfx_ok;      // bit 0 Content-Length, 1 Cache-Control, 2 max-age
  bit          in_tok;
  logic [31:0] acc;
  num_phase_e  num_phase;
  bit          num_neg;
  logic [31:0] clen_val;
  logic [31:0] age_val;

  hrs_out_t    owed_headers[$];
  int          mismatches;
  int          checked;

  function void restart();
    pos = '0; tail3 = '0; halted = 0; term_seen = 0; term_len = '0;
    tok_count = '0; mode = FIELD_NAME; ch_idx = '0; pfx_ok = 3'b111; in_tok = 0;
    acc = '0; num_phase = NUM_LEAD; num_neg = 0;
    clen_val = 32'hFFFF_FFFF;
    age_val = {1'b0, dflt_age};
  endfunction

  function void reset_all();
    dflt_age = DEFAULT_MAX_AGE_RST;
    limit_q = SCAN_LIMIT_RST;
    owed_headers.delete();
    restart();
  endfunction

  function int waiting();
    return owed_headers.size();
  endfunction

  task flag_mismatch(input string what);
    $display("%0t mismatch: %s", $realtime, what);
    mismatches++;
  endtask

  function void note_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    if (idx == REG_DEFAULT_MAX_AGE) begin
      dflt_age = val[30:0];
      if (pos == 0) age_val = {1'b0, dflt_age};
    end else if (idx == REG_SCAN_LIMIT) begin
      limit_q = val[15:0];
    end
  endfunction

  function logic [31:0] signed_value();
    return num_neg ? 32'd0 - acc : acc;
  endfunction

  // atoi-style: leading tab/VT/FF, one sign, then digits; saturates per sign
  function void digit_step(logic [7:0] b);
    logic [31:0] cap;
    logic [63:0] grown;
    bit is_digit;
    is_digit = (b >= CH_ZERO) && (b <= CH_NINE);
    if (num_phase == NUM_LEAD) begin
      if (b == CH_TAB || b == CH_VT || b == CH_FF) return;
      if (b == CH_PLUS || b == CH_MINUS) begin
        num_phase = NUM_DIGITS;
        num_neg = (b == CH_MINUS);
        return;
      end
      if (!is_digit) begin
        num_phase = NUM_DONE;
        num_neg = 0;
        return;
      end
      num_phase = NUM_DIGITS;
      num_neg = 0;
    end
    if (num_phase != NUM_DIGITS) return;
    if (!is_digit) begin
      num_phase = NUM_DONE;
      return;
    end
    cap = num_neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
    grown = 64'(acc) * 64'd10 + 64'(b - CH_ZERO);
    acc = (grown > 64'(cap)) ? cap : grown[31:0];
  endfunction

  function void token_char(logic [7:0] b);
    if (ch_idx < CLEN_LEN && b != 8'(clen_word[ch_idx])) pfx_ok[0] = 1'b0;
    if (ch_idx < CC_LEN && b != 8'(cc_word[ch_idx])) pfx_ok[1] = 1'b0;
    if (ch_idx < MA_LEN && b != 8'(age_word[ch_idx])) pfx_ok[2] = 1'b0;
    if (ch_idx < 4'd15) ch_idx++;
    if (mode == CLEN_VALUE || mode == AGE_VALUE) digit_step(b);
  endfunction

  function void token_end();
    case (mode)
      FIELD_NAME: begin
        // status line tokens are skipped
        if (tok_count < 2'd3) tok_count++;
        else if (pfx_ok[0] && ch_idx >= CLEN_LEN) mode = CLEN_VALUE;
        else if (pfx_ok[1] && ch_idx >= CC_LEN) mode = DIRECTIVE;
      end
      CLEN_VALUE: begin
        clen_val = signed_value();
        mode = FIELD_NAME;
      end
      DIRECTIVE: begin
        mode = (pfx_ok[2] && ch_idx >= MA_LEN) ? AGE_VALUE : FIELD_NAME;
      end
      default: begin
        age_val = signed_value();
        mode = FIELD_NAME;
      end
    endcase
    in_tok = 0;
  endfunction

  function void absorb_byte(hrs_in_t item);
    logic [7:0] b;
    hrs_out_t res;
    bit delim;
    b = item.data_byte;
    if (!halted && pos < limit_q) begin
      if (b == CH_NUL) begin
        halted = 1;
      end else begin
        delim = (b == CH_CR) || (b == CH_LF) || (b == CH_COLON) || (b == CH_SPACE) ||
                (mode >= DIRECTIVE && b == CH_EQ);
        if (delim) begin
          if (in_tok) token_end();
        end else begin
          if (!in_tok) begin
            in_tok = 1; ch_idx = '0; pfx_ok = 3'b111;
            acc = '0; num_phase = NUM_LEAD; num_neg = 0;
          end
          token_char(b);
        end
        if (b == CH_LF && tail3 == TERM_HEAD) begin
          term_seen = 1;
          term_len = pos + 16'd1;
          halted = 1;
        end
        tail3 = {tail3[15:0], b};
      end
    end
    if (pos != 16'hFFFF) pos++;
    if (item.last) begin
      res.found = term_seen;
      res.hdr_len = term_seen ? term_len : 16'd0;
      res.clen = term_seen ? clen_val : 32'hFFFF_FFFF;
      res.max_age = term_seen ? age_val : {1'b0, dflt_age};
      owed_headers.push_back(res);
      restart();
    end
  endfunction

  task match_result(input hrs_out_t got);
    hrs_out_t want;
    if (owed_headers.size() == 0) begin
      flag_mismatch("header summary popped with none outstanding");
      return;
    end
    want = owed_headers.pop_front();
    if (got.found !== want.found)
      flag_mismatch($sformatf("#%0d found got %0b want %0b", checked, got.found, want.found));
    if (got.hdr_len !== want.hdr_len)
      flag_mismatch($sformatf("#%0d hdr_len got %0d want %0d", checked,
                              got.hdr_len, want.hdr_len));
    if (got.clen !== want.clen)
      flag_mismatch($sformatf("#%0d clen got %0d want %0d", checked,
                              $signed(got.clen), $signed(want.clen)));
    if (got.max_age !== want.max_age)
      flag_mismatch($sformatf("#%0d max_age got %0d want %0d", checked,
                              $signed(got.max_age), $signed(want.max_age)));
    checked++;
  endtask
endclass

module testbench;
  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_push = 1'b0;
  hrs_in_t               in_data = '0;
  logic                  in_full;
  logic                  out_empty;
  logic                  out_pop = 1'b0;
  hrs_out_t              out_data;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  header_ledger ledger;
  logic [7:0]   msg[$];
  bit           steady = 1'b0;
  int           stall_left = 0;
  int           bytes_pushed = 0;

  http_response_header_scanner dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_push   (in_push),
    .in_data   (in_data),
    .in_full   (in_full),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always #5 clk = ~clk;

  initial begin
    #15_000_000;
    $display("** http_response_header_scanner: FAILED **");
    $finish;
  end

  // mostly short gaps, the odd long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 60);
  endfunction

  always @(negedge clk) begin
    if (stall_left > 0 && !steady) begin
      stall_left--;
      out_pop <= 1'b0;
    end else begin
      out_pop <= 1'b1;
      stall_left = (!steady && $urandom_range(99) < 30) ? pick_gap() : 0;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_pop && !out_empty) begin
      ledger.match_result(out_data);
    end
  end

  task push_byte(input logic [7:0] b, input logic fin);
    hrs_in_t item;
    int gap;
    item.data_byte = b;
    item.last = fin;
    gap = steady ? 0 : pick_gap();
    repeat (gap) begin
      @(negedge clk);
      in_push <= 1'b0;
    end
    @(negedge clk);
    in_push <= 1'b1;
    in_data <= item;
    @(posedge clk);
    while (in_full) @(posedge clk);
    ledger.absorb_byte(item);
    bytes_pushed++;
  endtask

  task send_message();
    steady = ($urandom_range(99) < 15);
    foreach (msg[i]) push_byte(msg[i], i == msg.size() - 1);
  endtask

  // hold off until every request has its summary, then let the pipe drain
  task settle();
    @(negedge clk);
    in_push <= 1'b0;
    while (ledger.waiting() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    ledger.note_reg(idx, val);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task add_text(input string s);
    for (int i = 0; i < s.len(); i++) msg.push_back(8'(s[i]));
  endtask

  task add_eol();
    msg.push_back(CH_CR);
    msg.push_back(CH_LF);
  endtask

  task line(input string s);
    add_text(s);
    add_eol();
  endtask

  function automatic logic [7:0] noise_byte();
    case ($urandom_range(9))
      0: return CH_CR;
      1: return CH_LF;
      2: return ($urandom_range(1) != 0) ? CH_COLON : CH_SPACE;
      3: return ($urandom_range(1) != 0) ? CH_NUL : CH_EQ;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  function automatic string mangle(input string s);
    string t;
    int r;
    t = s;
    r = $urandom_range(99);
    if (r < 8) t[$urandom_range(t.len() - 1)] = 8'($urandom_range(97, 122));
    else if (r < 14) t = t.substr(0, t.len() - 2);
    else if (r < 20) t = {t, "s"};
    return t;
  endfunction

  task add_sep();
    case ($urandom_range(5))
      0: add_text(":");
      1: add_text(" ");
      2: add_text(":  ");
      default: add_text(": ");
    endcase
  endtask

  task add_number();
    string d;
    int r;
    repeat (($urandom_range(3) == 0) ? $urandom_range(1, 2) : 0)
      case ($urandom_range(2))
        0: msg.push_back(CH_TAB);
        1: msg.push_back(CH_VT);
        default: msg.push_back(CH_FF);
      endcase
    r = $urandom_range(99);
    if (r < 12) msg.push_back(CH_PLUS);
    else if (r < 25) msg.push_back(CH_MINUS);
    r = $urandom_range(99);
    if (r < 45) begin
      d = $sformatf("%0d", $urandom_range(0, 99999));
    end else if (r < 65) begin
      d = "";
      repeat ($urandom_range(1, 13)) d = $sformatf("%s%0d", d, $urandom_range(9));
    end else if (r < 80) begin
      case ($urandom_range(5))
        0: d = "2147483647";
        1: d = "2147483648";
        2: d = "2147483646";
        3: d = "4294967296";
        4: d = "99999999999";
        default: d = "0";
      endcase
    end else if (r < 90) begin
      d = "";
    end else begin
      d = "x1";
    end
    add_text(d);
    if ($urandom_range(9) == 0) add_text("z9");
  endtask

  task add_directive();
    case ($urandom_range(9))
      5: add_text("no-cache");
      6: begin
        add_text("public, max-age=");
        add_number();
      end
      7: begin
        add_text("s-maxage=");
        add_number();
      end
      8: add_text("max-age");
      default: begin
        add_text(mangle("max-age"));
        msg.push_back(($urandom_range(5) == 0) ? CH_SPACE : CH_EQ);
        add_number();
      end
    endcase
  endtask

  task add_field();
    case ($urandom_range(9))
      0, 1, 2: begin
        add_text(mangle("Content-Length"));
        add_sep();
        add_number();
      end
      3, 4, 5: begin
        add_text(mangle("Cache-Control"));
        add_sep();
        add_directive();
      end
      6: add_text("Content-Type: text/html");
      7: begin
        add_text("Content-Length");
        add_sep();
      end
      8: add_text("Server: x=1");
      default: repeat ($urandom_range(1, 6)) msg.push_back(8'($urandom_range(97, 122)));
    endcase
    add_eol();
  endtask

  // mostly well-formed responses with random content; some broken, some pure noise
  task build_response();
    int kind;
    int cut;
    msg.delete();
    kind = $urandom_range(99);
    if (kind < 12) begin
      repeat ($urandom_range(1, 40)) msg.push_back(noise_byte());
      return;
    end
    case ($urandom_range(9))
      0: line("HTTP/1.0 404 NotFound");
      1: line("X Y");
      2: line("HTTP/1.1  200   OK");
      3: line("HTTP/1.1 200");
      default: line("HTTP/1.1 200 OK");
    endcase
    repeat ($urandom_range(0, 4)) add_field();
    if ($urandom_range(99) < 88) add_eol();
    repeat ($urandom_range(0, 6)) msg.push_back(noise_byte());
    if (kind < 25) begin
      if ($urandom_range(1) != 0) begin
        msg[$urandom_range(msg.size() - 1)] = noise_byte();
      end else begin
        cut = $urandom_range(msg.size() - 1);
        repeat (cut) msg.delete(msg.size() - 1);
      end
    end
  endtask

  initial begin
    int start_bytes;
    int spin;
    logic [30:0] dflt_pick;
    logic [15:0] lim_pick;
    ledger = new();
    ledger.reset_all();
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // reset values of both registers in force
    msg.delete();
    line("HTTP/1.1 200 OK");
    line("Content-Length: 1234");
    line("Cache-Control: max-age=300");
    add_eol();
    add_text("body");
    send_message();

    msg.delete();
    line("HTTP/1.1 200 OK");
    line("Content-Length: -2147483649");
    line("Cache-Control:max-age=2147483648");
    add_eol();
    send_message();

    // leading blanks, sign and trailing junk inside one value token
    msg.delete();
    line("HTTP/1.1 200 OK");
    add_text("Content-Length: ");
    msg.push_back(CH_TAB);
    msg.push_back(CH_VT);
    msg.push_back(CH_FF);
    line("+42x7");
    line("Cache-Control: max-age=-0");
    add_eol();
    send_message();

    // value token missing
    msg.delete();
    line("HTTP/1.1 204 NoContent");
    line("Content-Length:");
    add_eol();
    send_message();

    // NUL ends scanning
    msg.delete();
    line("HTTP/1.1 200 OK");
    line("Content-Length: 5");
    msg.push_back(CH_NUL);
    add_eol();
    add_eol();
    send_message();

    // anything past the terminator is ignored
    msg.delete();
    line("H 1 2");
    add_eol();
    line("Content-Length: 9");
    add_eol();
    send_message();

    // no terminator: fields seen do not count
    msg.delete();
    line("HTTP/1.1 200 OK");
    line("Content-Length: 10");
    line("Cache-Control: max-age=7");
    send_message();

    msg.delete();
    msg.push_back(8'hFF);
    send_message();

    // near-miss keywords
    msg.delete();
    line("HTTP/1.1 200 OK");
    line("Content-Lengthy: 8");
    line("Cache-Controller: max-agent=9");
    line("Content-Lengt: 3");
    line("Cache-Control: max-ag=4");
    msg.push_back(8'h80);
    add_eol();
    add_eol();
    send_message();

    msg.delete();
    line("HTTP/1.1 200 OK");
    line("Content-Length: abc");
    line("Cache-Control: public, max-age=11");
    add_eol();
    send_message();
    settle();

    // scan limit of 4, just enough for CR LF CR LF, zero default
    set_reg(REG_DEFAULT_MAX_AGE, '0);
    set_reg(REG_SCAN_LIMIT, 31'd4);
    msg.delete();
    add_eol();
    add_eol();
    send_message();
    msg.delete();
    add_text("x");
    add_eol();
    add_eol();
    send_message();
    settle();

    set_reg(REG_SCAN_LIMIT, 31'(SCAN_LIMIT_RST));
    msg.delete();
    line("HTTP/1.1 200 OK");
    line("Content-Length: 0");
    add_eol();
    send_message();
    settle();

    // widest settings
    set_reg(REG_DEFAULT_MAX_AGE, 31'h7FFF_FFFF);
    set_reg(REG_SCAN_LIMIT, {15'h7FFF, 16'hFFFF});
    msg.delete();
    line("HTTP/1.1 200 OK");
    line("Content-Length: 77");
    line("Cache-Control: max-age=5");
    add_eol();
    add_text("x");
    send_message();
    msg.delete();
    line("HTTP/1.1 200 OK");
    add_eol();
    send_message();
    settle();

    start_bytes = bytes_pushed;
    while (bytes_pushed - start_bytes < 450) begin
      case ($urandom_range(9))
        0: dflt_pick = '0;
        1: dflt_pick = 31'h7FFF_FFFF;
        2, 3: dflt_pick = DEFAULT_MAX_AGE_RST;
        4, 5: dflt_pick = 31'($urandom);
        default: dflt_pick = 31'($urandom_range(0, 1000000));
      endcase
      case ($urandom_range(9))
        0: lim_pick = 16'($urandom_range(4, 12));
        1, 2: lim_pick = 16'($urandom_range(16, 80));
        3, 4, 5: lim_pick = SCAN_LIMIT_RST;
        6, 7: lim_pick = 16'hFFFF;
        default: lim_pick = 16'($urandom_range(200, 65535));
      endcase
      if ($urandom_range(3) != 0) set_reg(REG_DEFAULT_MAX_AGE, dflt_pick);
      if ($urandom_range(3) != 0) set_reg(REG_SCAN_LIMIT, {15'($urandom), lim_pick});
      repeat ($urandom_range(4, 12)) begin
        build_response();
        send_message();
      end
      settle();
    end

    spin = 0;
    while (ledger.waiting() != 0 && spin < 20000) begin
      @(posedge clk);
      spin++;
    end
    repeat (10) @(posedge clk);
    if (ledger.waiting() != 0)
      ledger.flag_mismatch($sformatf("%0d header summaries never came out", ledger.waiting()));
    if (ledger.mismatches == 0) begin
      $display("** http_response_header_scanner: PASSED **");
    end else begin
      $display("** http_response_header_scanner: FAILED **");
    end
    $finish;
  end
endmodule

[http_response_header_scanner.f]
+incdir+rtl/core
rtl/core/hrs_pkg.sv
rtl/core/hrs_fifo.sv
rtl/core/hrs_front.sv
rtl/core/hrs_back.sv
rtl/core/http_response_header_scanner.sv
bench/testbench.sv
